// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the segment builder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DSB_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("segment builder assertion failed");

// next-cycle implication
`define DSB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("segment builder assertion failed");

`endif

// ===== design/dsb_pkg.sv =====
// ----------------------------------------------------------------------------
// dsb_pkg
// Types, constants and register codes of the DMA segment builder.
// ----------------------------------------------------------------------------
package dsb_pkg;

  localparam int unsigned PAGE_BYTES_DEFAULT = 4096;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned LEN_W      = 25;
  localparam int unsigned CONSUMED_W = 17;
  localparam int unsigned LIMIT_W    = 17;
  localparam int unsigned INDEX_W    = 16;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_BOUNCE = 2'd1,
    STATUS_NO_SEG = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_SEG_LEN      = 4'd0,
    CFG_BOUNDARY         = 4'd1,
    CFG_BOUNCE_THRESHOLD = 4'd2,
    CFG_SEG_LIMIT        = 4'd3
  } cfg_index_t;

  typedef struct packed {
    logic [ADDR_W-1:0] virt_addr;
    logic [ADDR_W-1:0] phys_addr;
    logic [LEN_W-1:0]  remaining_len;
    logic              start_load;
  } piece_t;

  typedef struct packed {
    logic [CONSUMED_W-1:0] consumed_len;
    status_t               status;
    logic [INDEX_W-1:0]    seg_index;
    logic [ADDR_W-1:0]     seg_phys_start;
    logic [LEN_W-1:0]      seg_length;
    logic                  opened_segment;
  } result_t;

  typedef struct packed {
    logic [LEN_W-1:0]   max_seg_len;
    logic [ADDR_W-1:0]  boundary;
    logic [ADDR_W-1:0]  bounce_threshold;
    logic [LIMIT_W-1:0] seg_limit;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W:0]    last_phys_end;
    logic [ADDR_W-1:0]  seg_phys;
    logic [ADDR_W-1:0]  seg_virt;
    logic [LEN_W-1:0]   seg_len;
    logic [INDEX_W-1:0] index;
  } seg_state_t;

  localparam cfg_t CFG_RESET = '{
    max_seg_len:      25'd65536,
    boundary:         32'd0,
    bounce_threshold: 32'd0,
    seg_limit:        17'd1
  };

endpackage

// ===== design/dsb_stream_if.sv =====
// ----------------------------------------------------------------------------
// dsb_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface dsb_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/dsb_cfg_if.sv =====
// ----------------------------------------------------------------------------
// dsb_cfg_if
// Register write channel: index and write data with valid/ready.
// ----------------------------------------------------------------------------
interface dsb_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [dsb_pkg::CFG_IDX_W-1:0]    index;
  logic [dsb_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/dsb_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// dsb_cfg_regs
// Configuration register bank written through the register channel.
// ----------------------------------------------------------------------------
module dsb_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  dsb_cfg_if.sink        cfg,
  output dsb_pkg::cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= dsb_pkg::CFG_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        dsb_pkg::CFG_MAX_SEG_LEN:      regs.max_seg_len      <= cfg.data[dsb_pkg::LEN_W-1:0];
        dsb_pkg::CFG_BOUNDARY:         regs.boundary         <= cfg.data;
        dsb_pkg::CFG_BOUNCE_THRESHOLD: regs.bounce_threshold <= cfg.data;
        dsb_pkg::CFG_SEG_LIMIT:        regs.seg_limit        <= cfg.data[dsb_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/dsb_piece_calc.sv =====
// ----------------------------------------------------------------------------
// dsb_piece_calc
// Piece length, merge decision and next segment state for one piece.
// ----------------------------------------------------------------------------
module dsb_piece_calc #(
  parameter int unsigned PAGE_BYTES = dsb_pkg::PAGE_BYTES_DEFAULT
) (
  input  dsb_pkg::piece_t     piece,
  input  dsb_pkg::cfg_t       regs,
  input  dsb_pkg::seg_state_t st,
  output dsb_pkg::seg_state_t st_next,
  output dsb_pkg::result_t    res
);

  localparam int unsigned PAGE_W = $clog2(PAGE_BYTES);
  localparam int unsigned SIZE_W = PAGE_W + 1;
  localparam int unsigned A_W    = dsb_pkg::ADDR_W;
  localparam int unsigned L_W    = dsb_pkg::LEN_W;

  logic [SIZE_W-1:0]          page_rest;
  logic [SIZE_W-1:0]          size_page;
  logic [SIZE_W-1:0]          size;
  logic [A_W:0]               bmask;
  logic [A_W:0]               win_edge;
  logic [A_W:0]               win_dist;
  logic                       bounce;
  logic                       merge;
  logic [L_W:0]               merged_len;
  logic [dsb_pkg::LIMIT_W-1:0] next_index;

  always_comb begin
    page_rest = SIZE_W'(PAGE_BYTES) - {1'b0, piece.virt_addr[PAGE_W-1:0]};
    size_page = (piece.remaining_len < L_W'(page_rest)) ?
                piece.remaining_len[SIZE_W-1:0] : page_rest;

    bmask    = ~{1'b0, regs.boundary - 32'd1};
    win_edge = ({1'b0, piece.phys_addr} + {1'b0, regs.boundary}) & bmask;
    win_dist = win_edge - {1'b0, piece.phys_addr};
    size     = size_page;
    if (regs.boundary != '0 && (A_W+1)'(size_page) > win_dist) begin
      size = win_dist[SIZE_W-1:0];
    end

    bounce     = (regs.bounce_threshold != '0) && (piece.phys_addr >= regs.bounce_threshold);
    merged_len = {1'b0, st.seg_len} + (L_W+1)'(size);
    merge      = !piece.start_load
              && ({1'b0, piece.phys_addr} == st.last_phys_end)
              && (piece.virt_addr == st.seg_virt + (piece.phys_addr - st.seg_phys))
              && (merged_len <= {1'b0, regs.max_seg_len})
              && ((regs.boundary == '0)
                  || ((st.seg_phys & bmask[A_W-1:0]) == (piece.phys_addr & bmask[A_W-1:0])));
    next_index = {1'b0, st.index} + 17'd1;

    st_next                = st;
    res.consumed_len       = '0;
    res.status             = dsb_pkg::STATUS_OK;
    res.opened_segment     = 1'b0;

    priority if (bounce) begin
      res.status = dsb_pkg::STATUS_BOUNCE;
    end else if (piece.remaining_len == '0) begin
      res.status = dsb_pkg::STATUS_OK;
    end else if (merge) begin
      st_next.seg_len       = merged_len[L_W-1:0];
      st_next.last_phys_end = {1'b0, piece.phys_addr} + (A_W+1)'(size);
      res.consumed_len      = dsb_pkg::CONSUMED_W'(size);
    end else if (!piece.start_load && next_index >= regs.seg_limit) begin
      res.status = dsb_pkg::STATUS_NO_SEG;
    end else begin
      st_next.index         = piece.start_load ? '0 : next_index[dsb_pkg::INDEX_W-1:0];
      st_next.seg_phys      = piece.phys_addr;
      st_next.seg_virt      = piece.virt_addr;
      st_next.seg_len       = L_W'(size);
      st_next.last_phys_end = {1'b0, piece.phys_addr} + (A_W+1)'(size);
      res.consumed_len      = dsb_pkg::CONSUMED_W'(size);
      res.opened_segment    = 1'b1;
    end

    res.seg_index      = st_next.index;
    res.seg_phys_start = st_next.seg_phys;
    res.seg_length     = st_next.seg_len;
  end

endmodule

// ===== design/dma_sg_segment_builder.sv =====
// An accepted piece beat is registered in the input register, its result
// in the output register. Throughput: one piece per cycle unless the
// result side stalls; the segment state register closes its update loop
// through the single piece calculation stage. While a result waits, the
// input register takes one more beat, then holds. Reset clears the segment
// state and both valid flags and loads the register defaults.
// ----------------------------------------------------------------------------
// dma_sg_segment_builder
// Scatter-gather list builder: one piece per beat, merged, opened or refused.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dma_sg_segment_builder #(
  parameter int unsigned PAGE_BYTES = dsb_pkg::PAGE_BYTES_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  dsb_cfg_if.sink      cfg,
  dsb_stream_if.sink   piece,
  dsb_stream_if.source result
);

  dsb_pkg::cfg_t       regs;
  dsb_pkg::seg_state_t st;
  dsb_pkg::seg_state_t st_next;
  dsb_pkg::piece_t     s1_item;
  dsb_pkg::result_t    calc_res;
  dsb_pkg::result_t    out_item;
  logic                s1_valid;
  logic                out_valid;
  logic                fire;

  dsb_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  dsb_piece_calc #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_calc (
    .piece   (s1_item),
    .regs    (regs),
    .st      (st),
    .st_next (st_next),
    .res     (calc_res)
  );

  assign fire        = s1_valid && (!out_valid || result.ready);
  assign piece.ready = !s1_valid || fire;
  assign result.valid = out_valid;
  assign result.data  = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (piece.ready) begin
      s1_valid <= piece.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (piece.valid && piece.ready) begin
      s1_item <= piece.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        st        <= st_next;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item <= calc_res;
    end
  end

  `DSB_ASSERT(a_err_no_bytes, clk, rst, out_valid && out_item.status != dsb_pkg::STATUS_OK, out_item.consumed_len == '0 && !out_item.opened_segment)
  `DSB_ASSERT(a_open_len, clk, rst, out_valid && out_item.opened_segment, out_item.seg_length == dsb_pkg::LEN_W'(out_item.consumed_len))
  `DSB_ASSERT(a_merge_cap, clk, rst, out_valid && !out_item.opened_segment && out_item.consumed_len != '0, out_item.seg_length <= regs.max_seg_len)
  `DSB_ASSERT_NEXT(a_idx_step, clk, rst, fire && calc_res.opened_segment && !s1_item.start_load, st.index == $past(st.index) + 16'd1)
  `DSB_ASSERT_NEXT(a_hold_state, clk, rst, !fire, st == $past(st))

endmodule
